// ===== rtl/ppc_pkg.sv =====
// ============================================================================
// Polygon point containment package
// Shared item, command and result types, plus fixed constants.
// ============================================================================
package ppc_pkg;

    // Width of one coordinate on the ports.
    localparam int COORD_W = 16;

    // Width of the vertex total reported in each result.
    localparam int TOTAL_W = 5;

    // Vertex count of a single triangle.
    localparam int TRI_VERTS = 3;

    // Command codes passed from the front end to the engine.
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    // Input item as seen on the push side.
    typedef struct packed {
        logic                      mode;
        logic                      restart;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } in_item_t;

    // Result item as seen on the pop side.
    typedef struct packed {
        logic               inside_res;
        logic               polygon_valid;
        logic               dropped;
        logic [TOTAL_W-1:0] vertex_total;
    } out_item_t;

    // Classified command held in the queue between front end and engine.
    typedef struct packed {
        logic [CMD_W-1:0]          kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } cmd_t;

endpackage

// ===== rtl/ppc_front.sv =====
// ============================================================================
// Polygon point containment front end
// Accepts input transactions and classifies each one into a command.
// ============================================================================
module ppc_front (
    input  logic              push,
    input  ppc_pkg::in_item_t item,
    input  logic              q_full,
    output logic              full,
    output logic              cmd_push,
    output ppc_pkg::cmd_t     cmd
);

    // A transaction is taken whenever the command queue has room.
    assign full     = q_full;
    assign cmd_push = push && !q_full;

    // Decode mode and restart into one command code.
    always_comb
    begin
        if (item.mode)
        begin
            cmd.kind = ppc_pkg::CMD_QUERY;
        end
        else if (item.restart)
        begin
            cmd.kind = ppc_pkg::CMD_RESTART;
        end
        else
        begin
            cmd.kind = ppc_pkg::CMD_APPEND;
        end
        cmd.x = item.coord_x;
        cmd.y = item.coord_y;
    end

endmodule

// ===== rtl/ppc_queue.sv =====
// ============================================================================
// Polygon point containment command queue
// Two-entry queue that decouples the front end from the engine.
// ============================================================================
module ppc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ppc_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output ppc_pkg::cmd_t rd_data
);

    ppc_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          do_wr;
    logic          do_rd;

    // Status and head of the queue.
    assign full     = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        fill_next   = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/ppc_engine.sv =====
// ============================================================================
// Polygon point containment engine
// Holds the polygon and runs appends and pipelined triangle tests.
// ============================================================================
module ppc_engine #(
    parameter int MAX_VERTICES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  ppc_pkg::cmd_t      cmd,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output ppc_pkg::out_item_t result
);

    localparam int CW = ppc_pkg::COORD_W;
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int SW = CW + NW;
    localparam int DW = SW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int TW = XW + 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Control state.
    logic [1:0]         state_reg, state_next;
    logic [NW-1:0]      count_reg, count_next;
    logic signed [SW-1:0] sum_x_reg, sum_x_next;
    logic signed [SW-1:0] sum_y_reg, sum_y_next;
    logic [NW-1:0]      k_reg, k_next;
    logic               fan_reg, fan_next;
    logic               acc_reg, acc_next;
    logic               res_valid_reg, res_valid_next;
    ppc_pkg::out_item_t res_reg, res_next;

    // Vertex memory and the scaled query point.
    logic [2*CW-1:0]      vert_mem [MAX_VERTICES];
    logic [2*CW-1:0]      rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 issue;
    logic                 issue_eval;
    logic                 issue_last;
    logic                 load_point;
    logic signed [SW-1:0] px_reg, py_reg;
    logic signed [SW:0]   qx_full, qy_full;
    logic [NW-1:0]        base;

    // Pipeline stages.
    logic                 rd_v_reg, rd_eval_reg;
    logic                 s1_v_reg, s1_eval_reg;
    logic signed [SW-1:0] s1_x_reg, s1_y_reg;
    logic signed [SW:0]   sx_full, sy_full;
    logic signed [SW-1:0] prev_x_reg, prev_y_reg, prev2_x_reg, prev2_y_reg;
    logic signed [SW-1:0] ax, ay, bx, by;
    logic                 e_v_reg;
    logic signed [DW-1:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic                 p_v_reg;
    logic signed [PW-1:0] p_reg [6];
    logic                 x_v_reg;
    logic signed [XW-1:0] d_reg, u_reg, v_reg;
    logic signed [TW-1:0] df, uf, vf;
    logic                 hit;
    logic                 pipe_idle;

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    // Query point scaled by the vertex count.
    assign qx_full = cmd.x * $signed({1'b0, count_reg});
    assign qy_full = cmd.y * $signed({1'b0, count_reg});

    // Read address walks the stored vertices, wrapping to vertex zero.
    assign rd_addr    = (k_reg == count_reg) ? '0 : k_reg[AW-1:0];
    assign issue_eval = fan_reg ? (k_reg != '0) : (k_reg == NW'(2));
    assign issue_last = fan_reg ? (k_reg == count_reg) : (k_reg == NW'(2));
    assign wr_addr    = base[AW-1:0];
    assign pipe_idle  = !rd_v_reg && !s1_v_reg && !e_v_reg && !p_v_reg && !x_v_reg;

    // Sequencer for appends and queries.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        k_next         = k_reg;
        fan_next       = fan_reg;
        acc_next       = acc_reg | (x_v_reg & hit);
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        cmd_take       = 1'b0;
        mem_we         = 1'b0;
        issue          = 1'b0;
        load_point     = 1'b0;
        base           = (cmd.kind == ppc_pkg::CMD_RESTART) ? '0 : count_reg;

        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !res_valid_reg)
                begin
                    cmd_take = 1'b1;
                    if (cmd.kind == ppc_pkg::CMD_QUERY)
                    begin
                        if (count_reg < NW'(ppc_pkg::TRI_VERTS))
                        begin
                            res_next.inside_res    = 1'b0;
                            res_next.polygon_valid = 1'b0;
                            res_next.dropped       = 1'b0;
                            res_next.vertex_total  = ppc_pkg::TOTAL_W'(count_reg);
                            res_valid_next         = 1'b1;
                        end
                        else
                        begin
                            load_point = 1'b1;
                            state_next = ST_ISSUE;
                            k_next     = '0;
                            fan_next   = (count_reg != NW'(ppc_pkg::TRI_VERTS));
                            acc_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        res_next.inside_res    = 1'b0;
                        res_next.polygon_valid = 1'b0;
                        if (base < NW'(MAX_VERTICES))
                        begin
                            mem_we     = 1'b1;
                            count_next = base + NW'(1);
                            if (cmd.kind == ppc_pkg::CMD_RESTART)
                            begin
                                sum_x_next = SW'(cmd.x);
                                sum_y_next = SW'(cmd.y);
                            end
                            else
                            begin
                                sum_x_next = sum_x_reg + SW'(cmd.x);
                                sum_y_next = sum_y_reg + SW'(cmd.y);
                            end
                            res_next.dropped      = 1'b0;
                            res_next.vertex_total = ppc_pkg::TOTAL_W'(base + NW'(1));
                        end
                        else
                        begin
                            res_next.dropped      = 1'b1;
                            res_next.vertex_total = ppc_pkg::TOTAL_W'(count_reg);
                        end
                        res_valid_next = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                issue  = 1'b1;
                k_next = k_reg + NW'(1);
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_idle)
                begin
                    res_next.inside_res    = acc_reg;
                    res_next.polygon_valid = 1'b1;
                    res_next.dropped       = 1'b0;
                    res_next.vertex_total  = ppc_pkg::TOTAL_W'(count_reg);
                    res_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            k_reg         <= '0;
            fan_reg       <= 1'b0;
            acc_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            e_v_reg       <= 1'b0;
            p_v_reg       <= 1'b0;
            x_v_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            k_reg         <= k_next;
            fan_reg       <= fan_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
            rd_v_reg      <= issue;
            s1_v_reg      <= rd_v_reg;
            e_v_reg       <= s1_v_reg && s1_eval_reg;
            p_v_reg       <= e_v_reg;
            x_v_reg       <= p_v_reg;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Vertex memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vert_mem[wr_addr] <= {cmd.x, cmd.y};
        end
        if (issue)
        begin
            rd_data_reg <= vert_mem[rd_addr];
        end
        rd_eval_reg <= issue_eval;
        if (load_point)
        begin
            px_reg <= qx_full[SW-1:0];
            py_reg <= qy_full[SW-1:0];
        end
    end

    // Scale each vertex read by the vertex count.
    assign sx_full = $signed(rd_data_reg[2*CW-1:CW]) * $signed({1'b0, count_reg});
    assign sy_full = $signed(rd_data_reg[CW-1:0]) * $signed({1'b0, count_reg});

    always_ff @(posedge clk)
    begin
        s1_x_reg    <= sx_full[SW-1:0];
        s1_y_reg    <= sy_full[SW-1:0];
        s1_eval_reg <= rd_eval_reg;
        if (s1_v_reg)
        begin
            prev2_x_reg <= prev_x_reg;
            prev2_y_reg <= prev_y_reg;
            prev_x_reg  <= s1_x_reg;
            prev_y_reg  <= s1_y_reg;
        end
    end

    // Triangle corners: the plain triangle, or a fan triangle around the centroid.
    assign ax = fan_reg ? prev_x_reg : prev2_x_reg;
    assign ay = fan_reg ? prev_y_reg : prev2_y_reg;
    assign bx = fan_reg ? sum_x_reg : prev_x_reg;
    assign by = fan_reg ? sum_y_reg : prev_y_reg;

    // Edge vectors relative to the first corner.
    always_ff @(posedge clk)
    begin
        e0x_reg <= DW'(s1_x_reg) - DW'(ax);
        e0y_reg <= DW'(s1_y_reg) - DW'(ay);
        e1x_reg <= DW'(bx) - DW'(ax);
        e1y_reg <= DW'(by) - DW'(ay);
        e2x_reg <= DW'(px_reg) - DW'(ax);
        e2y_reg <= DW'(py_reg) - DW'(ay);
    end

    // Cross product terms, one multiplier each.
    always_ff @(posedge clk)
    begin
        p_reg[0] <= e0x_reg * e1y_reg;
        p_reg[1] <= e0y_reg * e1x_reg;
        p_reg[2] <= e2x_reg * e1y_reg;
        p_reg[3] <= e2y_reg * e1x_reg;
        p_reg[4] <= e0x_reg * e2y_reg;
        p_reg[5] <= e0y_reg * e2x_reg;
    end

    // Denominator and the two barycentric numerators.
    always_ff @(posedge clk)
    begin
        d_reg <= XW'(p_reg[0]) - XW'(p_reg[1]);
        u_reg <= XW'(p_reg[2]) - XW'(p_reg[3]);
        v_reg <= XW'(p_reg[4]) - XW'(p_reg[5]);
    end

    // Fold the sign of the denominator in and test the point.
    always_comb
    begin
        df = TW'(d_reg);
        uf = TW'(u_reg);
        vf = TW'(v_reg);
        if (d_reg[XW-1])
        begin
            df = -df;
            uf = -uf;
            vf = -vf;
        end
        hit = (d_reg != '0) && !uf[TW-1] && !vf[TW-1] && ((uf + vf) <= df);
    end

endmodule

// ===== rtl/polygon_point_containment.sv =====
// ============================================================================
// Polygon point containment
// Stores polygon vertices and answers point containment queries.
// ============================================================================
// Append transactions store one vertex; a vertex beyond MAX_VERTICES is
// dropped and flagged. A query on n > 3 vertices tests n fan triangles
// around the centroid: one triangle enters the test pipeline per cycle,
// paced by the single read port of the vertex memory, followed by the
// pipeline drain. A two-entry command queue sits in front of the engine
// and a result register behind it, so push and pop stall independently.
// The engine starts a new transaction only once the previous result has
// been popped.
module polygon_point_containment #(
    parameter int MAX_VERTICES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ppc_pkg::in_item_t  item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output ppc_pkg::out_item_t result
);

    ppc_pkg::cmd_t front_cmd;
    ppc_pkg::cmd_t queue_cmd;
    logic          front_push;
    logic          queue_full;
    logic          queue_valid;
    logic          engine_take;

    // Classify incoming transactions.
    ppc_front u_front (
        .push     (push),
        .item     (item),
        .q_full   (queue_full),
        .full     (full),
        .cmd_push (front_push),
        .cmd      (front_cmd)
    );

    // Command queue between front end and engine.
    ppc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_cmd),
        .full     (queue_full),
        .rd_en    (engine_take),
        .rd_valid (queue_valid),
        .rd_data  (queue_cmd)
    );

    // Polygon store and containment engine.
    ppc_engine #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_take  (engine_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== sim/tb_polygon_point_containment.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Polygon point containment testbench
// Directed table of polygon builds and queries, then random polygons and
// queries under several push and pop idling phases, all checked against a
// local exact-integer containment predictor.
// ============================================================================
module tb_polygon_point_containment;

    localparam int MAX_V = 16;
    localparam int WATCHDOG = 5000;

    logic               clk;
    logic               rst_n;
    logic               push;
    ppc_pkg::in_item_t  item;
    logic               full;
    logic               empty;
    logic               pop;
    ppc_pkg::out_item_t result;

    polygon_point_containment #(.MAX_VERTICES(MAX_V)) uut (
        .clk(clk), .rst_n(rst_n), .push(push), .item(item), .full(full),
        .empty(empty), .pop(pop), .result(result)
    );

    // Directed row: item plus an optional typed-in expectation.
    typedef struct {
        ppc_pkg::in_item_t  stim;
        bit                 fixed;
        ppc_pkg::out_item_t want;
    } row_t;

    // Directed stimulus table.
    row_t dir [$];

    // Predictor state.
    longint             poly_x [MAX_V];
    longint             poly_y [MAX_V];
    int                 poly_n;
    longint             cen_x;
    longint             cen_y;
    ppc_pkg::out_item_t pending [$];

    int errors;
    int idle_cycles;
    int push_idle_pct;
    int pop_stall_pct;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Barycentric triangle test with signs in place of the division.
    function automatic bit tri_contains(longint px, longint py, longint ax, longint ay,
                                        longint bx, longint by, longint cx, longint cy);
        longint d;
        longint u;
        longint v;
        d = (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
        u = (px - ax) * (by - ay) - (py - ay) * (bx - ax);
        v = (cx - ax) * (py - ay) - (cy - ay) * (px - ax);
        if (d == 0)
            return 1'b0;
        if (d < 0)
        begin
            d = -d;
            u = -u;
            v = -v;
        end
        return (u >= 0) && (v >= 0) && (u + v <= d);
    endfunction

    // Update the stored polygon and work out the result of one transaction.
    function automatic ppc_pkg::out_item_t containment_of(ppc_pkg::in_item_t it);
        ppc_pkg::out_item_t r;
        longint             n;
        int                 j;
        r = '0;
        if (it.mode == 1'b0)
        begin
            if (it.restart)
            begin
                poly_n = 0;
                cen_x = 0;
                cen_y = 0;
            end
            if (poly_n < MAX_V)
            begin
                poly_x[poly_n] = it.coord_x;
                poly_y[poly_n] = it.coord_y;
                poly_n++;
                cen_x += it.coord_x;
                cen_y += it.coord_y;
            end
            else
                r.dropped = 1'b1;
        end
        else if (poly_n >= ppc_pkg::TRI_VERTS)
        begin
            n = poly_n;
            r.polygon_valid = 1'b1;
            if (poly_n == ppc_pkg::TRI_VERTS)
                r.inside_res = tri_contains(it.coord_x * n, it.coord_y * n,
                    poly_x[0] * n, poly_y[0] * n, poly_x[1] * n, poly_y[1] * n,
                    poly_x[2] * n, poly_y[2] * n);
            else
                for (int i = 0; i < poly_n && !r.inside_res; i++)
                begin
                    j = (i + 1 == poly_n) ? 0 : i + 1;
                    r.inside_res = tri_contains(it.coord_x * n, it.coord_y * n,
                        poly_x[i] * n, poly_y[i] * n, cen_x, cen_y,
                        poly_x[j] * n, poly_y[j] * n);
                end
        end
        r.vertex_total = poly_n[ppc_pkg::TOTAL_W-1:0];
        return r;
    endfunction

    function automatic ppc_pkg::in_item_t mk(bit m, bit rs, int x, int y);
        ppc_pkg::in_item_t it;
        it.mode = m;
        it.restart = rs;
        it.coord_x = x[15:0];
        it.coord_y = y[15:0];
        return it;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(ppc_pkg::in_item_t stim, bit fixed,
                                    ppc_pkg::out_item_t want);
        row_t rw;
        rw.stim = stim;
        rw.fixed = fixed;
        rw.want = want;
        dir.insert(dir.size(), rw);
    endfunction

    // Present one transaction and hold it until accepted.
    task automatic send(ppc_pkg::in_item_t it, bit fixed, ppc_pkg::out_item_t want);
        ppc_pkg::out_item_t got;
        while (push_idle_pct > 0 && $urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        got = containment_of(it);
        if (fixed && got != want)
        begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch: predictor %p, typed %p", got, want);
        end
        pending.insert(pending.size(), got);
        @(negedge clk);
    endtask

    // Result side: random pop stalls and field checks.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !(pop_stall_pct > 0 && $urandom_range(99) < pop_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (pop && !empty)
            begin
                if (pending.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %p", result);
                end
                else
                begin
                    if (result.inside_res !== pending[0].inside_res
                        || result.polygon_valid !== pending[0].polygon_valid
                        || result.dropped !== pending[0].dropped
                        || result.vertex_total !== pending[0].vertex_total)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("result mismatch: expected %p, actual %p",
                                     pending[0], result);
                    end
                    void'(pending.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb_polygon_point_containment: FAIL");
            $finish;
        end
    end

    // Random polygon around a center; small radius keeps many hits.
    task automatic random_polygon(int nv);
        int cx;
        int cy;
        int rad;
        cx = $urandom_range(4000) - 2000;
        cy = $urandom_range(4000) - 2000;
        rad = $urandom_range(2000, 1);
        if ($urandom_range(9) == 0)
        begin
            cx = 0;
            cy = 0;
            rad = 32767;
        end
        for (int k = 0; k < nv; k++)
            send(mk(1'b0, k == 0, cx + $urandom_range(2 * rad) - rad,
                    cy + $urandom_range(2 * rad) - rad), 1'b0, '0);
        for (int q = 0; q < 6; q++)
            send(mk(1'b1, 1'($urandom_range(1)),
                    ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                             : cx + $urandom_range(2 * rad) - rad,
                    ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                             : cy + $urandom_range(2 * rad) - rad),
                 1'b0, '0);
    endtask

    // Stimulus.
    initial
    begin
        ppc_pkg::out_item_t w;
        int                 sent;
        int                 nv;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        errors = 0;
        idle_cycles = 0;
        push_idle_pct = 0;
        pop_stall_pct = 0;
        poly_n = 0;
        cen_x = 0;
        cen_y = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: query on empty store, extremes, triangle, degenerate triangle.
        w = '0;
        add_row(mk(1'b1, 1'b0, 0, 0), 1'b1, w);
        w.vertex_total = 5'd1;
        add_row(mk(1'b0, 1'b1, -32768, -32768), 1'b1, w);
        w.vertex_total = 5'd2;
        add_row(mk(1'b0, 1'b0, 32767, -32768), 1'b1, w);
        w = '0; w.vertex_total = 5'd2;
        add_row(mk(1'b1, 1'b1, 0, 0), 1'b1, w);
        w.vertex_total = 5'd3;
        add_row(mk(1'b0, 1'b0, 0, 32767), 1'b1, w);
        add_row(mk(1'b1, 1'b0, 0, 0), 1'b0, w);
        add_row(mk(1'b1, 1'b0, -32768, -32768), 1'b0, w);
        add_row(mk(1'b1, 1'b0, 32767, 32767), 1'b0, w);
        add_row(mk(1'b1, 1'b0, 0, -32768), 1'b0, w);
        add_row(mk(1'b0, 1'b0, -32768, 32767), 1'b0, w);
        add_row(mk(1'b1, 1'b0, -1, 0), 1'b0, w);
        add_row(mk(1'b1, 1'b0, 32767, -32768), 1'b0, w);
        // Degenerate triangle on a line.
        add_row(mk(1'b0, 1'b1, 0, 0), 1'b0, w);
        add_row(mk(1'b0, 1'b0, 5, 5), 1'b0, w);
        add_row(mk(1'b0, 1'b0, 10, 10), 1'b0, w);
        add_row(mk(1'b1, 1'b0, 5, 5), 1'b0, w);
        foreach (dir[i])
            send(dir[i].stim, dir[i].fixed, dir[i].want);
        // Fill past capacity, then a restart on the full store.
        for (int k = 0; k < MAX_V + 2; k++)
            send(mk(1'b0, 1'b0, k * 100, (k % 2) * 300), 1'b0, '0);
        w = '0; w.vertex_total = 5'd1;
        send(mk(1'b0, 1'b1, 1, 1), 1'b1, w);

        // Random phases with different idling.
        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            push_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 17) : 0;
            pop_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 67 : 17) : 0;
            while (sent < (ph + 1) * 130)
            begin
                nv = ($urandom_range(7) == 0) ? int'($urandom_range(18, 1))
                                              : int'($urandom_range(8, 3));
                if ($urandom_range(9) == 0)
                begin
                    send(mk(1'($urandom_range(1)), 1'($urandom_range(1)),
                            $urandom_range(65535), $urandom_range(65535)), 1'b0, '0);
                    sent++;
                end
                else
                begin
                    random_polygon(nv);
                    sent += nv + 6;
                end
            end
            // Clear push idling at the end of each phase.
            push_idle_pct = 0;
        end
        push <= 1'b0;
        pop_stall_pct = 0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb_polygon_point_containment: PASS");
        else
            $display("tb_polygon_point_containment: FAIL");
        $finish;
    end
endmodule
